[rtl/assert_macros.svh]
// Assertion macros shared by the decimal number writer RTL.
// No dependencies; each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LDNW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define LDNW_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/ldnw_pkg.sv]
// Package for the decimal number writer: widths, LCD codes, types.
// No dependencies.
package ldnw_pkg;

    // Largest padding width honored
    localparam int MAX_DIGITS = 5;
    localparam int PAD_LIMIT  = 6;
    localparam logic [2:0] PAD_MAX =
        3'((MAX_DIGITS < PAD_LIMIT) ? MAX_DIGITS : PAD_LIMIT);

    // Value and BCD geometry
    localparam int VAL_W = 16;
    localparam int MAG_W = 15;
    localparam int NDIG  = 5;
    localparam int DIG_W = 4;
    localparam int CNT_W = $clog2(MAG_W + 1);

    // LCD bus codes
    localparam logic [7:0] CMD_LINE1  = 8'h80;
    localparam logic [7:0] LINE2_OFS  = 8'h40;
    localparam logic [7:0] CMD_LINE2  = CMD_LINE1 + LINE2_OFS;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [3:0] LAST_COL   = 4'd15;

    typedef logic [DIG_W-1:0] digit_t;

    // Item fields handed to the sequencer
    typedef struct packed {
        logic       line2;
        logic [3:0] col;
        logic       neg;
        logic [2:0] minw;
    } ldnw_job_t;

    // Converter status and digits
    typedef struct packed {
        logic                  busy;
        logic [2:0]            ndig;
        logic [NDIG-1:0][DIG_W-1:0] digits;
    } ldnw_bcd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR_SIGN,
        ST_MINUS,
        ST_JUMP_SIGN,
        ST_ADDR,
        ST_LOAD,
        ST_DIGIT,
        ST_JUMP
    } ldnw_state_t;

endpackage

[rtl/ldnw_in_if.sv]
// Input channel of the decimal number writer: valid/ready plus item fields.
// Depends on nothing.
interface ldnw_in_if;
    logic        valid;
    logic        ready;
    logic        second_line;
    logic [3:0]  column;
    logic signed [15:0] value;
    logic [2:0]  min_width;

    modport source (output valid, second_line, column, value, min_width, input ready);
    modport sink   (input valid, second_line, column, value, min_width, output ready);
endinterface

[rtl/ldnw_out_if.sv]
// Output channel of the decimal number writer: one LCD bus write per transfer.
// Depends on nothing.
interface ldnw_out_if;
    logic       valid;
    logic       ready;
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;

    modport source (output valid, is_data, bus_byte, last, input ready);
    modport sink   (input valid, is_data, bus_byte, last, output ready);
endinterface

[rtl/ldnw_bcd_conv.sv]
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on ldnw_pkg.
module ldnw_bcd_conv
    import ldnw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [MAG_W-1:0] mag,
    output ldnw_bcd_t        bcd
);

    logic [MAG_W-1:0]        bin_reg, bin_next;
    logic [NDIG*DIG_W-1:0]   dec_reg, dec_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [NDIG*DIG_W-1:0]   dec_adj;
    logic [2:0]              nd;

    // Correct each digit, then shift one binary bit in
    always_comb
    begin
        for (int k = 0; k < NDIG; k++)
        begin
            if (dec_reg[k*DIG_W +: DIG_W] >= DIG_W'(5))
                dec_adj[k*DIG_W +: DIG_W] = dec_reg[k*DIG_W +: DIG_W] + DIG_W'(3);
            else
                dec_adj[k*DIG_W +: DIG_W] = dec_reg[k*DIG_W +: DIG_W];
        end
        bin_next = bin_reg;
        dec_next = dec_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            bin_next = mag;
            dec_next = '0;
            cnt_next = CNT_W'(MAG_W);
        end
        else if (cnt_reg != '0)
        begin
            dec_next = {dec_adj[NDIG*DIG_W-2:0], bin_reg[MAG_W-1]};
            bin_next = {bin_reg[MAG_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        dec_reg <= dec_next;
    end

    // Count significant digits (zero has one)
    always_comb
    begin
        nd = 3'd1;
        for (int k = 1; k < NDIG; k++)
        begin
            if (dec_reg[k*DIG_W +: DIG_W] != '0)
                nd = 3'(k + 1);
        end
    end

    assign bcd.busy   = (cnt_reg != '0);
    assign bcd.ndig   = nd;
    assign bcd.digits = dec_reg;

endmodule

[rtl/ldnw_seq.sv]
// Write sequencer: address commands, sign, digits and line jump, one write
// per transfer through an output register. Depends on ldnw_pkg, ldnw_out_if.
module ldnw_seq
    import ldnw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ldnw_job_t         job,
    input  ldnw_bcd_t         bcd,
    ldnw_out_if.source        lcd
);

    ldnw_state_t state_reg, state_next;
    logic        line2_reg, line2_next;
    logic [3:0]  col_reg, col_next;
    logic [2:0]  minw_reg, minw_next;
    logic        pend_reg, pend_next;
    logic        fin_reg, fin_next;
    logic [2:0]  pos_reg, pos_next;
    logic        ovalid_reg, ovalid_next;
    logic        is_data_reg, is_data_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;

    logic        free, emit, w_is_data, w_last, jmp;
    logic [7:0]  w_byte, addr_byte;
    logic [2:0]  minw_sat, width;
    digit_t      cur_digit;

    assign free      = !ovalid_reg || lcd.ready;
    assign addr_byte = (line2_reg ? CMD_LINE2 : CMD_LINE1) + {4'b0, col_reg};
    assign minw_sat  = (minw_reg > PAD_MAX) ? PAD_MAX : minw_reg;
    assign width     = (minw_sat > bcd.ndig) ? minw_sat : bcd.ndig;
    assign cur_digit = (pos_reg < 3'(NDIG)) ? bcd.digits[pos_reg] : '0;
    assign jmp       = pend_reg && (col_reg == LAST_COL);

    // Next state and the write to present
    always_comb
    begin
        state_next = state_reg;
        line2_next = line2_reg;
        col_next   = col_reg;
        minw_next  = minw_reg;
        pend_next  = pend_reg;
        fin_next   = fin_reg;
        pos_next   = pos_reg;
        emit       = 1'b0;
        w_is_data  = 1'b0;
        w_byte     = addr_byte;
        w_last     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    line2_next = job.line2;
                    col_next   = job.col;
                    minw_next  = job.minw;
                    state_next = job.neg ? ST_ADDR_SIGN : ST_ADDR;
                end
            end
            ST_ADDR_SIGN:
            begin
                emit = 1'b1;
                if (free)
                    state_next = ST_MINUS;
            end
            ST_MINUS:
            begin
                emit      = 1'b1;
                w_is_data = 1'b1;
                w_byte    = CH_MINUS;
                if (free)
                begin
                    state_next = (!line2_reg && col_reg == LAST_COL) ? ST_JUMP_SIGN : ST_ADDR;
                    if (col_reg == LAST_COL)
                    begin
                        line2_next = 1'b1;
                        col_next   = '0;
                    end
                    else
                        col_next = col_reg + 4'd1;
                end
            end
            ST_JUMP_SIGN:
            begin
                emit   = 1'b1;
                w_byte = CMD_LINE2;
                if (free)
                    state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                emit = 1'b1;
                if (free)
                begin
                    pend_next  = !line2_reg;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // Hold until the converter has its digits
                if (!bcd.busy)
                begin
                    pos_next   = width - 3'd1;
                    fin_next   = 1'b0;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                emit      = 1'b1;
                w_is_data = 1'b1;
                w_byte    = CH_ZERO + {4'b0, cur_digit};
                w_last    = (pos_reg == '0) && !jmp;
                if (free)
                begin
                    col_next = col_reg + 4'd1;
                    if (pos_reg == '0)
                        fin_next = 1'b1;
                    else
                        pos_next = pos_reg - 3'd1;
                    if (jmp)
                    begin
                        pend_next  = 1'b0;
                        state_next = ST_JUMP;
                    end
                    else if (pos_reg == '0)
                        state_next = ST_IDLE;
                end
            end
            ST_JUMP:
            begin
                emit   = 1'b1;
                w_byte = CMD_LINE2;
                w_last = fin_reg;
                if (free)
                    state_next = fin_reg ? ST_IDLE : ST_DIGIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Load the output register when it frees up, drop it after a transfer
    always_comb
    begin
        ovalid_next  = ovalid_reg;
        is_data_next = is_data_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        if (emit && free)
        begin
            ovalid_next  = 1'b1;
            is_data_next = w_is_data;
            byte_next    = w_byte;
            last_next    = w_last;
        end
        else if (lcd.ready)
            ovalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        line2_reg   <= line2_next;
        col_reg     <= col_next;
        minw_reg    <= minw_next;
        pend_reg    <= pend_next;
        fin_reg     <= fin_next;
        pos_reg     <= pos_next;
        is_data_reg <= is_data_next;
        byte_reg    <= byte_next;
        last_reg    <= last_next;
    end

    assign lcd.valid    = ovalid_reg;
    assign lcd.is_data  = is_data_reg;
    assign lcd.bus_byte = byte_reg;
    assign lcd.last     = last_reg;

endmodule

[rtl/lcd_decimal_number_writer_core.sv]
// The first bus write is offered from the output register, loaded once the
// sequencer has left idle. One item at a time; the bit-serial BCD converter must
// finish before digits go out, and each item writes address commands, an optional
// minus sign, its digits (padding included) and a line-two jump where needed.
// Reset (rst_n, asynchronous): clears the busy flag, converter count, sequencer state and
// output valid; no stored data survives between items.
`include "assert_macros.svh"
module lcd_decimal_number_writer_core
    import ldnw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ldnw_in_if.sink     num,
    ldnw_out_if.source  lcd
);

    logic             busy_reg, busy_next;
    logic             start;
    logic [VAL_W-1:0] neg_val;
    logic [MAG_W-1:0] mag;
    ldnw_job_t        job;
    ldnw_bcd_t        bcd;

    // Take one item at a time
    assign num.ready = !busy_reg;
    assign start     = num.valid && num.ready;

    // Magnitude, with the most negative value clamped
    assign neg_val = num.value[VAL_W-1] ? (~num.value + VAL_W'(1)) : num.value;
    assign mag     = neg_val[VAL_W-1] ? {MAG_W{1'b1}} : neg_val[MAG_W-1:0];

    assign job.line2 = num.second_line;
    assign job.col   = num.column;
    assign job.neg   = num.value[VAL_W-1];
    assign job.minw  = num.min_width;

    // Release on the transfer of the final write
    always_comb
    begin
        busy_next = busy_reg;
        if (start)
            busy_next = 1'b1;
        else if (lcd.valid && lcd.ready && lcd.last)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    ldnw_bcd_conv u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mag   (mag),
        .bcd   (bcd)
    );

    ldnw_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .job   (job),
        .bcd   (bcd),
        .lcd   (lcd)
    );

    `LDNW_NEVER(a_out_while_idle, lcd.valid && num.ready, "bus write offered while input side idle")
    `LDNW_NEVER(a_conv_while_idle, bcd.busy && !busy_reg, "converter running with no item in flight")
    `LDNW_ASSERT(a_last_frees, (lcd.valid && lcd.ready && lcd.last) |=> num.ready, "final transfer did not free the input")

endmodule
